// File: hdl/dedup_pkg.sv
// shared types and constants for the device dedup table
package dedup_pkg;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_WAIT,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam int unsigned AddrW = 48;
  localparam int unsigned TimeW = 32;
  localparam logic [31:0] WindowReset = 32'd20000;

  // slot word stored in the table memory
  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] addr;
    logic [7:0]       rssi;
    logic [7:0]       channel;
    logic [TimeW-1:0] stamp;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef struct packed {
    logic [1:0]       opcode;
    logic [31:0]      now_ms;
    logic [AddrW-1:0] wifi_addr;
    logic [AddrW-1:0] ble_addr;
    logic signed [7:0] wifi_rssi;
    logic signed [7:0] bt_rssi;
    logic [7:0]       wifi_channel;
    logic             query_kind;
    logic [5:0]       query_index;
  } req_t;

  typedef struct packed {
    logic             stored;
    logic             found;
    logic [AddrW-1:0] entry_addr;
    logic signed [7:0] entry_rssi;
    logic [7:0]       entry_channel;
    logic [31:0]      entry_last_seen;
    logic             entry_active;
    logic [5:0]       kind_count;
    logic [5:0]       kind_active_count;
    logic [31:0]      logged_total;
  } rsp_t;

endpackage

// File: hdl/dedup_if.sv
// valid/ready channel carrying one payload
interface dedup_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dedup_ram.sv
// generic ram with one write port and one read port, registered read
module dedup_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hdl/dedup_seen_table_ring_evict.sv
// top level of the seen-device table
// One transfer in, one transfer out. Each accepted item sweeps every slot of the
// table memory (one read per cycle, with registered read data); the single read
// port sets the timing. Opcode 3, a dropped record, and a read found in the
// active sweep make one sweep; clear first frees the used flip-flops, then makes
// the counting sweep; a read that needs the second sweep over inactive entries
// makes both sweeps; a stored record makes two, since after its sweep it writes
// back the slot and then sweeps again to count.
// During the sweep the slot is matched, the first free slot is noted, the
// per-kind and active counts are summed, and for a read the rank is tracked.
// Used bits are kept in flip-flops, so reset needs no clearing pass. The result
// sits in an output register until its transfer; the next item is taken no
// earlier than the cycle after that transfer.
module dedup_seen_table_ring_evict #(
  parameter int unsigned CAPACITY = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [31:0]             cfg_wdata_i,
  dedup_if.sink                   req,
  dedup_if.source                 rsp
);
  import dedup_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  state_e state_q, state_d;

  logic [31:0]         window_q;
  logic [CAPACITY-1:0] used_q;
  logic [IdxW-1:0]     cursor_q;
  logic [31:0]         total_q;
  req_t                req_q;
  rsp_t                rsp_q;
  logic                rsp_valid_q;

  // scan bookkeeping
  logic [IdxW-1:0] rd_idx_q;     // address issued this cycle
  logic [IdxW-1:0] chk_idx_q;    // address whose data arrives now
  logic            chk_vld_q;
  logic            pass_q;       // read: 0 active entries, 1 inactive ones; record: 1 on the recount pass
  logic            hit_q, free_q, found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [6:0]      rank_q;
  logic [CntW-1:0] cnt_q, act_q;
  slot_t           fnd_q;
  logic            fnd_act_q;

  slot_t rdata;
  logic  we;
  logic [IdxW-1:0] waddr;
  slot_t wdata;

  // decoded record
  logic             is_ble;
  logic [AddrW-1:0] rec_addr;
  assign is_ble   = (req_q.ble_addr != '0) && (req_q.wifi_addr == '0);
  assign rec_addr = is_ble ? req_q.ble_addr : req_q.wifi_addr;

  dedup_ram #(.Width(SlotW), .Depth(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // per-slot checks on the data returning from memory
  logic chk_used, kind_ok, act_ok, match;
  logic [31:0] age;
  assign chk_used = chk_vld_q && used_q[chk_idx_q];
  assign kind_ok  = chk_used && (rdata.kind == req_q.query_kind);
  assign age      = req_q.now_ms - rdata.stamp;
  assign act_ok   = age < window_q;
  assign match    = chk_used && (rdata.kind == is_ble) && (rdata.addr == rec_addr);

  // ranking only for the read opcode
  logic want_here;
  assign want_here = kind_ok && (act_ok == !pass_q) && !found_q
                     && (op_e'(req_q.opcode) == OP_READ);

  // the second read sweep only ranks; its counts come from the first sweep
  logic count_en;
  assign count_en = !(pass_q && (op_e'(req_q.opcode) == OP_READ));

  assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  logic slot_pick_free;
  logic [IdxW-1:0] tgt;
  assign slot_pick_free = free_q;
  assign tgt = hit_q ? hit_idx_q : (slot_pick_free ? free_idx_q : cursor_q);

  assign we    = (state_q == ST_WRITE);
  assign waddr = tgt;
  always_comb begin
    wdata.kind    = is_ble;
    wdata.addr    = rec_addr;
    wdata.rssi    = is_ble ? req_q.bt_rssi : req_q.wifi_rssi;
    wdata.channel = is_ble ? 8'd0 : req_q.wifi_channel;
    wdata.stamp   = req_q.now_ms;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req.valid && req.ready) begin
                  state_d = (op_e'(req.data.opcode) == OP_CLEAR) ? ST_CLEAR : ST_SCAN;
                end
      ST_CLEAR: state_d = ST_SCAN;
      ST_SCAN:  if (rd_idx_q == LastIdx) state_d = ST_WAIT;
      ST_WAIT:  begin
                  if (op_e'(req_q.opcode) == OP_READ && !pass_q && !(found_q || want_here
                      && rank_q == {1'b0, req_q.query_index})) begin
                    state_d = ST_SCAN;
                  end else if (op_e'(req_q.opcode) == OP_RECORD && rec_addr != '0 && !pass_q) begin
                    state_d = ST_WRITE;
                  end else begin
                    state_d = ST_DONE;
                  end
                end
      ST_WRITE: state_d = ST_CLEAR;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WindowReset;
      used_q      <= '0;
      cursor_q    <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
      chk_vld_q   <= 1'b0;
      rd_idx_q    <= '0;
      pass_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;
      if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
      chk_vld_q <= (state_q == ST_SCAN);

      unique case (state_q)
        ST_IDLE: begin
          rd_idx_q <= '0;
          pass_q   <= 1'b0;
        end
        ST_CLEAR: begin
          // entered on clear opcode, or after a write back (recount pass)
          if (op_e'(req_q.opcode) == OP_CLEAR) begin
            used_q   <= '0;
            cursor_q <= '0;
            total_q  <= '0;
          end
          rd_idx_q <= '0;
          pass_q   <= (op_e'(req_q.opcode) == OP_RECORD);
        end
        ST_SCAN: rd_idx_q <= (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
        ST_WAIT: if (state_d == ST_SCAN) pass_q <= 1'b1;
        ST_WRITE: begin
          used_q[tgt] <= 1'b1;
          total_q     <= total_q + 32'd1;
          if (!hit_q && !slot_pick_free) begin
            cursor_q <= (cursor_q == LastIdx) ? '0 : cursor_q + 1'b1;
          end
        end
        ST_DONE: rsp_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload and scan accumulators
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
    if (state_q == ST_IDLE || state_q == ST_CLEAR) begin
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      cnt_q   <= '0;
      act_q   <= '0;
      if (state_q == ST_IDLE || op_e'(req_q.opcode) != OP_READ) begin
        found_q <= 1'b0;
        rank_q  <= '0;
      end
    end
    if (state_q == ST_WAIT || state_q == ST_DONE) begin
      chk_idx_q <= '0;
    end else begin
      chk_idx_q <= rd_idx_q;
    end
    if (chk_vld_q) begin
      if (match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= chk_idx_q;
      end
      if (!used_q[chk_idx_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= chk_idx_q;
      end
      if (kind_ok && count_en) begin
        cnt_q <= cnt_q + 1'b1;
        if (act_ok) act_q <= act_q + 1'b1;
      end
      if (want_here) begin
        if (rank_q == {1'b0, req_q.query_index}) begin
          found_q   <= 1'b1;
          fnd_q     <= rdata;
          fnd_act_q <= act_ok;
        end
        rank_q <= rank_q + 1'b1;
      end
    end
    if (state_q == ST_DONE) begin
      rsp_q.stored            <= (op_e'(req_q.opcode) == OP_RECORD) && (rec_addr != '0);
      rsp_q.found             <= found_q;
      rsp_q.entry_addr        <= found_q ? fnd_q.addr : '0;
      rsp_q.entry_rssi        <= found_q ? fnd_q.rssi : '0;
      rsp_q.entry_channel     <= found_q ? fnd_q.channel : '0;
      rsp_q.entry_last_seen   <= found_q ? fnd_q.stamp : '0;
      rsp_q.entry_active      <= found_q && fnd_act_q;
      rsp_q.kind_count        <= 6'(cnt_q);
      rsp_q.kind_active_count <= 6'(act_q);
      rsp_q.logged_total      <= total_q;
    end
  end

  // a result is never overwritten before its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp.ready |=> rsp_valid_q) else $error("result dropped");
  // no item is taken while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |-> state_q == ST_IDLE) else $error("item taken while busy");
  // the memory is written only for a record with a nonzero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (op_e'(req_q.opcode) == OP_RECORD) && (rec_addr != '0)) else $error("bad write");
endmodule
